FILE: hw/rtl/sia_pkg.sv
// Shared types and constants for the slot index allocator.
`timescale 1ns / 1ps
package sia_pkg;

    localparam int SLOTS_DEF       = 4096;
    localparam int SERIAL_BITS_DEF = 32;
    localparam int OWNER_W         = 64;
    localparam int CMD_W           = 2;
    localparam int STAT_W          = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERIAL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;

    // Decoded action of one command after the counter stage.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_POP,
        OP_FRESH,
        OP_FULL,
        OP_FREE,
        OP_SERIAL,
        OP_BAD
    } t_op;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_stage_ctl;

endpackage

FILE: hw/rtl/sia_free_stack.sv
// Free stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
module sia_free_stack #(
    parameter int SLOTS = sia_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [IDX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [IDX_W-1:0] o_rdata
);

    logic [IDX_W-1:0] r_mem [SLOTS];
    logic [IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sia_slot_store.sv
// Per-slot serial and owner memories with write-to-read forwarding on the serial memory.
`timescale 1ns / 1ps
module sia_slot_store #(
    parameter int SLOTS       = sia_pkg::SLOTS_DEF,
    parameter int SERIAL_BITS = sia_pkg::SERIAL_BITS_DEF,
    parameter int IDX_W       = $clog2(SLOTS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_re,
    input  logic [IDX_W-1:0]           i_raddr,
    input  logic                       i_we_ser,
    input  logic                       i_we_own,
    input  logic [IDX_W-1:0]           i_waddr,
    input  logic [SERIAL_BITS-1:0]     i_wser,
    input  logic [sia_pkg::OWNER_W-1:0] i_wown,
    output logic [SERIAL_BITS-1:0]     o_rser
);

    logic [SERIAL_BITS-1:0]      r_ser [SLOTS];
    logic [sia_pkg::OWNER_W-1:0] r_own [SLOTS];
    logic [SERIAL_BITS-1:0]      r_rd;
    logic [IDX_W-1:0]            r_raddr;
    logic                        r_wb_vld;
    logic [IDX_W-1:0]            r_wb_addr;
    logic [SERIAL_BITS-1:0]      r_wb_data;

    always_ff @(posedge i_clk) begin
        if (i_we_ser) begin
            r_ser[i_waddr] <= i_wser;
        end
        if (i_we_own) begin
            r_own[i_waddr] <= i_wown;
        end
        if (i_re) begin
            r_rd      <= r_ser[i_raddr];
            r_raddr   <= i_raddr;
            r_wb_addr <= i_waddr;
            r_wb_data <= i_wser;
        end
    end

    // Remember a write that lands on the same edge as the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
        end else if (i_re) begin
            r_wb_vld <= i_we_ser;
        end
    end

    assign o_rser = (r_wb_vld && (r_wb_addr == r_raddr)) ? r_wb_data : r_rd;

endmodule

FILE: hw/rtl/sia_ctrl.sv
// Stack pointer, high-water counter, live counter and command decode.
`timescale 1ns / 1ps
module sia_ctrl #(
    parameter int SLOTS = sia_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(SLOTS),
    parameter int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [sia_pkg::CMD_W-1:0] i_cmd,
    input  logic [IDX_W-1:0]         i_idx,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    output sia_pkg::t_stage_ctl      o_ctl,
    output logic [IDX_W-1:0]         o_slot,
    output logic [IDX_W-1:0]         o_pop_slot,
    output logic [CNT_W-1:0]         o_live,
    output logic [CNT_W-1:0]         o_free
);

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    logic [CNT_W-1:0]    r_free_top, n_free_top;
    logic [CNT_W-1:0]    r_high_water, n_high_water;
    logic [CNT_W-1:0]    r_live, n_live;
    logic [CNT_W-1:0]    r_capacity;
    sia_pkg::t_stage_ctl r_ctl;
    logic [IDX_W-1:0]    r_slot, n_slot;
    sia_pkg::t_op        n_op;
    logic [CNT_W-1:0]    w_limit;
    logic                w_push, w_pop, w_idx_bad;

    assign w_limit   = (r_capacity < SLOTS_C) ? r_capacity : SLOTS_C;
    assign w_idx_bad = ({{(CNT_W-IDX_W){1'b0}}, i_idx} >= r_high_water);

    always_comb begin
        n_free_top   = r_free_top;
        n_high_water = r_high_water;
        n_live       = r_live;
        n_slot       = i_idx;
        n_op         = sia_pkg::OP_NOP;
        w_push       = 1'b0;
        w_pop        = 1'b0;
        case (i_cmd)
            sia_pkg::CMD_ALLOC: begin
                if (r_free_top != '0) begin
                    n_op       = sia_pkg::OP_POP;
                    w_pop      = 1'b1;
                    n_free_top = r_free_top - 1'b1;
                end else if (r_high_water < w_limit) begin
                    n_op         = sia_pkg::OP_FRESH;
                    n_slot       = r_high_water[IDX_W-1:0];
                    n_high_water = r_high_water + 1'b1;
                end else begin
                    n_op = sia_pkg::OP_FULL;
                end
                if (n_op != sia_pkg::OP_FULL && r_live < SLOTS_C) begin
                    n_live = r_live + 1'b1;
                end
            end
            sia_pkg::CMD_FREE: begin
                if (w_idx_bad) begin
                    n_op = sia_pkg::OP_BAD;
                end else begin
                    n_op = sia_pkg::OP_FREE;
                    // drop the push when the stack is already full
                    if (r_free_top < SLOTS_C) begin
                        w_push     = 1'b1;
                        n_free_top = r_free_top + 1'b1;
                    end
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
            end
            sia_pkg::CMD_SERIAL: begin
                n_op = w_idx_bad ? sia_pkg::OP_BAD : sia_pkg::OP_SERIAL;
            end
            default: begin
                n_op = sia_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top   <= '0;
            r_high_water <= '0;
            r_live       <= '0;
            r_capacity   <= SLOTS_C;
            r_ctl.vld    <= 1'b0;
            r_ctl.op     <= sia_pkg::OP_NOP;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_en) begin
                r_ctl.vld <= i_vld;
                r_ctl.op  <= n_op;
                if (i_vld) begin
                    r_free_top   <= n_free_top;
                    r_high_water <= n_high_water;
                    r_live       <= n_live;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slot <= n_slot;
        end
    end

    sia_free_stack #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_en && i_vld && w_push),
        .i_waddr (r_free_top[IDX_W-1:0]),
        .i_wdata (i_idx),
        .i_re    (i_en && i_vld && w_pop),
        .i_raddr (n_free_top[IDX_W-1:0]),
        .o_rdata (o_pop_slot)
    );

    assign o_ctl  = r_ctl;
    assign o_slot = r_slot;
    // The item in the second stage sees exactly its own post-step counts.
    assign o_live = r_live;
    assign o_free = r_free_top;

endmodule

FILE: hw/rtl/slot_index_allocator_unit.sv
// Slot index allocator: LIFO free list with high-water fallback and slot serials.
//
// Input stream s_axis carries one command per transfer: allocate, free, or
// fetch-and-increment serial. Output stream m_axis carries one result per
// command: granted index, serial before increment, status and the live and
// free counts after the command.
// The capacity register is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. It limits how many fresh indices the high-water counter
// may ever issue.
// Pipeline: input register at the edge that accepts a command, counter stage
// with memory reads, result register.
// Throughput: one command per cycle while m_axis accepts results; the counter
// stage and the read-modify write of the serial memory overlap across items.
// When m_axis is stalled the whole pipeline holds and s_axis_tready drops.
// Reset clears the counters and pipeline valids and sets capacity to the
// slot count; the memories are not cleared, every readable entry is
// written by an allocate first.
`timescale 1ns / 1ps
module slot_index_allocator_unit #(
    parameter int SLOTS       = sia_pkg::SLOTS_DEF,
    parameter int SERIAL_BITS = sia_pkg::SERIAL_BITS_DEF,
    parameter int IDX_W       = $clog2(SLOTS),
    parameter int CNT_W       = $clog2(SLOTS + 1),
    parameter int IN_W  = ((sia_pkg::CMD_W + IDX_W + SERIAL_BITS + sia_pkg::OWNER_W + 7) / 8) * 8,
    parameter int OUT_W = ((IDX_W + SERIAL_BITS + sia_pkg::STAT_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd, slot_index, serial_in, object_ref (lowest bits first)
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // granted_index, serial_out, status, live_count, free_count (lowest bits first)
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int IN_IDX = sia_pkg::CMD_W;
    localparam int IN_SER = IN_IDX + IDX_W;
    localparam int IN_OWN = IN_SER + SERIAL_BITS;
    localparam int O_SER  = IDX_W;
    localparam int O_ST   = O_SER + SERIAL_BITS;
    localparam int O_LIVE = O_ST + sia_pkg::STAT_W;
    localparam int O_FREE = O_LIVE + CNT_W;

    logic                         w_en;
    logic                         r_s1_vld;
    logic [sia_pkg::CMD_W-1:0]    r_s1_cmd;
    logic [IDX_W-1:0]             r_s1_idx;
    logic [SERIAL_BITS-1:0]       r_s1_ser;
    logic [sia_pkg::OWNER_W-1:0]  r_s1_own;
    logic [SERIAL_BITS-1:0]       r_s2_ser;
    logic [sia_pkg::OWNER_W-1:0]  r_s2_own;
    sia_pkg::t_stage_ctl          w_ctl;
    logic [IDX_W-1:0]             w_slot, w_pop_slot, w_grant;
    logic [CNT_W-1:0]             w_live, w_free;
    logic [SERIAL_BITS-1:0]       w_rser;
    logic                         w_alloc_ok, w_wr;
    logic                         w_we_ser, w_we_own;
    logic [IDX_W-1:0]             w_waddr;
    logic [SERIAL_BITS-1:0]       w_wser;
    logic [sia_pkg::OWNER_W-1:0]  w_wown;
    logic                         r_out_vld;
    logic [OUT_W-1:0]             r_out_data, n_out_data;

    // Advance every stage together unless the result register is held.
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= s_axis_tvalid;
            r_out_vld <= w_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_cmd   <= s_axis_tdata[IN_IDX-1:0];
            r_s1_idx   <= s_axis_tdata[IN_SER-1:IN_IDX];
            r_s1_ser   <= s_axis_tdata[IN_OWN-1:IN_SER];
            r_s1_own   <= s_axis_tdata[IN_OWN+sia_pkg::OWNER_W-1:IN_OWN];
            r_s2_ser   <= r_s1_ser;
            r_s2_own   <= r_s1_own;
            r_out_data <= n_out_data;
        end
    end

    sia_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (r_s1_vld),
        .i_cmd       (r_s1_cmd),
        .i_idx       (r_s1_idx),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ctl       (w_ctl),
        .o_slot      (w_slot),
        .o_pop_slot  (w_pop_slot),
        .o_live      (w_live),
        .o_free      (w_free)
    );

    assign w_alloc_ok = (w_ctl.op == sia_pkg::OP_POP) || (w_ctl.op == sia_pkg::OP_FRESH);
    assign w_grant    = (w_ctl.op == sia_pkg::OP_POP) ? w_pop_slot : w_slot;
    assign w_wr       = w_en && w_ctl.vld;

    // Second stage: write back the slot that the command touched.
    always_comb begin
        w_we_ser = 1'b0;
        w_we_own = 1'b0;
        w_waddr  = w_slot;
        w_wser   = '0;
        w_wown   = '0;
        case (w_ctl.op)
            sia_pkg::OP_POP, sia_pkg::OP_FRESH: begin
                w_we_ser = w_wr;
                w_we_own = w_wr;
                w_waddr  = w_grant;
                w_wser   = r_s2_ser;
                w_wown   = r_s2_own;
            end
            sia_pkg::OP_FREE: begin
                w_we_ser = w_wr;
                w_we_own = w_wr;
            end
            sia_pkg::OP_SERIAL: begin
                w_we_ser = w_wr;
                w_wser   = w_rser + 1'b1;
            end
            default: begin
                w_we_ser = 1'b0;
            end
        endcase
    end

    sia_slot_store #(
        .SLOTS       (SLOTS),
        .SERIAL_BITS (SERIAL_BITS),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_re     (w_en),
        .i_raddr  (r_s1_idx),
        .i_we_ser (w_we_ser),
        .i_we_own (w_we_own),
        .i_waddr  (w_waddr),
        .i_wser   (w_wser),
        .i_wown   (w_wown),
        .o_rser   (w_rser)
    );

    always_comb begin
        n_out_data = '0;
        if (w_alloc_ok) begin
            n_out_data[IDX_W-1:0] = w_grant;
        end
        if (w_ctl.op == sia_pkg::OP_SERIAL) begin
            n_out_data[O_ST-1:O_SER] = w_rser;
        end
        case (w_ctl.op)
            sia_pkg::OP_FULL: n_out_data[O_LIVE-1:O_ST] = sia_pkg::ST_FULL;
            sia_pkg::OP_BAD:  n_out_data[O_LIVE-1:O_ST] = sia_pkg::ST_BADIDX;
            default:          n_out_data[O_LIVE-1:O_ST] = sia_pkg::ST_OK;
        endcase
        n_out_data[O_FREE-1:O_LIVE]       = w_live;
        n_out_data[O_FREE+CNT_W-1:O_FREE] = w_free;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_free <= CNT_W'(SLOTS))
        else $error("free stack depth above slot count");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_live <= CNT_W'(SLOTS))
        else $error("live count above slot count");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data[O_LIVE-1:O_ST] == sia_pkg::ST_FULL)
        |-> (r_out_data[O_ST-1:0] == '0))
        else $error("full result carries an index or serial");

    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.vld && w_en) |=> r_out_vld)
        else $error("second stage item lost on the way to the result register");
`endif

endmodule

FILE: dv/slot_index_allocator_checker.sv
// Scoreboard for the slot index allocator: predicts every command's result and checks the result stream.
`timescale 1ns / 1ps
module slot_index_allocator_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_tvalid,
    input  logic                          i_req_tready,
    // cmd, slot_index, serial_in, object_ref (lowest bits first)
    input  logic [111:0]                  i_req_tdata,
    input  logic                          i_rsp_tvalid,
    input  logic                          i_rsp_tready,
    // granted_index, serial_out, status, live_count, free_count (lowest bits first)
    input  logic [71:0]                   i_rsp_tdata,
    input  logic                          i_cfg_we,
    input  logic [12:0]                   i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_issued,
    output int                            o_stack_depth,
    output logic [sia_pkg::SLOTS_DEF-1:0] o_live_map
);

    localparam int IDX_W = 12;
    localparam int CNT_W = 13;

    typedef struct packed {
        logic [sia_pkg::OWNER_W-1:0]         object_ref;
        logic [sia_pkg::SERIAL_BITS_DEF-1:0] serial_in;
        logic [IDX_W-1:0]                    slot_index;
        logic [sia_pkg::CMD_W-1:0]           cmd;
    } t_command;

    typedef struct packed {
        logic [CNT_W-1:0]                    free_count;
        logic [CNT_W-1:0]                    live_count;
        logic [sia_pkg::STAT_W-1:0]          status;
        logic [sia_pkg::SERIAL_BITS_DEF-1:0] serial_out;
        logic [IDX_W-1:0]                    granted_index;
    } t_outcome;

    // The owner reference never reaches the output, so only serials are kept.
    logic [IDX_W-1:0]                    free_stack  [sia_pkg::SLOTS_DEF];
    logic [sia_pkg::SERIAL_BITS_DEF-1:0] slot_serial [sia_pkg::SLOTS_DEF];
    logic [sia_pkg::SLOTS_DEF-1:0]       slot_live = '0;
    logic [CNT_W-1:0]                    capacity  = CNT_W'(sia_pkg::SLOTS_DEF);
    int                                  stack_depth = 0;
    int                                  issued      = 0;
    int                                  live_slots  = 0;
    int                                  mismatches  = 0;
    t_outcome                            awaited_outcomes [$];

    function automatic t_outcome apply_command(input t_command c);
        t_outcome         o;
        logic [IDX_W-1:0] slot;
        bit               granted;
        int               fresh_limit;
        o           = '0;
        o.status    = sia_pkg::ST_OK;
        slot        = '0;
        granted     = 1'b0;
        fresh_limit = (int'(capacity) < sia_pkg::SLOTS_DEF) ? int'(capacity)
                                                             : sia_pkg::SLOTS_DEF;
        case (c.cmd)
            sia_pkg::CMD_ALLOC: begin
                // Reuse the most recently freed slot before touching the high-water mark.
                if (stack_depth > 0) begin
                    stack_depth--;
                    slot    = free_stack[stack_depth];
                    granted = 1'b1;
                end else if (issued < fresh_limit) begin
                    slot    = IDX_W'(issued);
                    issued++;
                    granted = 1'b1;
                end else begin
                    o.status = sia_pkg::ST_FULL;
                end
                if (granted) begin
                    slot_serial[slot] = c.serial_in;
                    slot_live[slot]   = 1'b1;
                    if (live_slots < sia_pkg::SLOTS_DEF) live_slots++;
                    o.granted_index = slot;
                end
            end
            sia_pkg::CMD_FREE: begin
                if (int'(c.slot_index) >= issued) begin
                    o.status = sia_pkg::ST_BADIDX;
                end else begin
                    slot_serial[c.slot_index] = '0;
                    slot_live[c.slot_index]   = 1'b0;
                    // Double frees push again; drop the push once the stack is full.
                    if (stack_depth < sia_pkg::SLOTS_DEF) begin
                        free_stack[stack_depth] = c.slot_index;
                        stack_depth++;
                    end
                    if (live_slots > 0) live_slots--;
                end
            end
            sia_pkg::CMD_SERIAL: begin
                if (int'(c.slot_index) >= issued) begin
                    o.status = sia_pkg::ST_BADIDX;
                end else begin
                    o.serial_out              = slot_serial[c.slot_index];
                    slot_serial[c.slot_index] = o.serial_out + 1'b1;
                end
            end
            default: ;
        endcase
        o.live_count = CNT_W'(live_slots);
        o.free_count = CNT_W'(stack_depth);
        return o;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : track_transfers
        t_command cmd_in;
        t_outcome predicted;
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            stack_depth = 0;
            issued      = 0;
            live_slots  = 0;
            slot_live   = '0;
            capacity    = CNT_W'(sia_pkg::SLOTS_DEF);
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_req_tvalid && i_req_tready) begin
                cmd_in           = i_req_tdata[$bits(t_command)-1:0];
                predicted        = apply_command(cmd_in);
                awaited_outcomes = {awaited_outcomes, predicted};
            end
            if (i_rsp_tvalid && i_rsp_tready) begin
                got = i_rsp_tdata;
                if (awaited_outcomes.size() == 0) begin
                    $error("result transfer with no command outstanding: 0x%0h", i_rsp_tdata);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("granted_index", 32'(want.granted_index),
                                32'(got.granted_index));
                    check_field("serial_out", want.serial_out, got.serial_out);
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("live_count", 32'(want.live_count), 32'(got.live_count));
                    check_field("free_count", 32'(want.free_count), 32'(got.free_count));
                end
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= awaited_outcomes.size();
        o_issued      <= issued;
        o_stack_depth <= stack_depth;
        o_live_map    <= slot_live;
    end

endmodule

FILE: dv/slot_index_allocator_unit_tb.sv
// Testbench top for the slot index allocator: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module slot_index_allocator_unit_tb;

    localparam int IN_W         = 112;
    localparam int OUT_W        = 72;
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [sia_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_W-1:0]               s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_W-1:0]              m_axis_tdata;
    logic                          i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]              i_cfg_wdata   = '0;

    int                            fail_count;
    int                            pending;
    int                            issued;
    int                            stack_depth;
    logic [sia_pkg::SLOTS_DEF-1:0] live_map;
    int                            quiet_cycles = 0;
    int                            calm_left    = 0;

    always #6 i_clk = ~i_clk;

    slot_index_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    slot_index_allocator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_tvalid  (s_axis_tvalid),
        .i_req_tready  (s_axis_tready),
        .i_req_tdata   (s_axis_tdata),
        .i_rsp_tvalid  (m_axis_tvalid),
        .i_rsp_tready  (m_axis_tready),
        .i_rsp_tdata   (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_issued      (issued),
        .o_stack_depth (stack_depth),
        .o_live_map    (live_map)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Mostly a slot that is currently live, sometimes any index at all.
    function automatic logic [IDX_W-1:0] pick_live_slot();
        logic [IDX_W-1:0] idx;
        idx = IDX_W'($urandom_range(0, sia_pkg::SLOTS_DEF - 1));
        if (issued > 0 && $urandom_range(0, 9) != 0) begin
            for (int tries = 0; tries < 16; tries++) begin
                idx = IDX_W'($urandom_range(0, issued - 1));
                if (live_map[idx]) break;
            end
        end
        return idx;
    endfunction

    function automatic logic [IDX_W-1:0] pick_issued_slot();
        if (issued > 0 && $urandom_range(0, 7) != 0)
            return IDX_W'($urandom_range(0, issued - 1));
        return IDX_W'($urandom_range(0, sia_pkg::SLOTS_DEF - 1));
    endfunction

    task automatic send_command(input logic [sia_pkg::CMD_W-1:0] cmd,
                                input logic [IDX_W-1:0] slot,
                                input logic [sia_pkg::SERIAL_BITS_DEF-1:0] serial,
                                input logic [sia_pkg::OWNER_W-1:0] owner);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, owner, serial, slot, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            gap       = 0;
        end else begin
            gap = idle_cycles();
        end
        // Keep valid up across back-to-back transfers; drop it only for a real gap.
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_command();
        logic [sia_pkg::SERIAL_BITS_DEF-1:0] serial;
        logic [sia_pkg::OWNER_W-1:0]         owner;
        int                                  r;
        serial = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
        owner  = {$urandom, $urandom};
        r      = $urandom_range(0, 99);
        if (r < 45)
            send_command(sia_pkg::CMD_ALLOC, IDX_W'($urandom_range(0, sia_pkg::SLOTS_DEF - 1)),
                         serial, owner);
        else if (r < 70)
            send_command(sia_pkg::CMD_FREE, pick_live_slot(), serial, owner);
        else if (r < 95)
            send_command(sia_pkg::CMD_SERIAL, pick_issued_slot(), serial, owner);
        else
            send_command(CMD_UNUSED, IDX_W'($urandom_range(0, sia_pkg::SLOTS_DEF - 1)),
                         serial, owner);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_command();
    endtask

    // Drop valid, then hold until every outstanding command has its result.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : result_pacing
        int run;
        int stall;
        wait (i_rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            stall = idle_cycles();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int fill;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing issued yet: both slot commands must be rejected.
        send_command(sia_pkg::CMD_SERIAL, 12'd0, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_FREE, 12'd0, 32'd0, 64'd0);
        send_command(CMD_UNUSED, 12'd0, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'd5, {$urandom, $urandom});
        // Serial at all-ones wraps to zero.
        send_command(sia_pkg::CMD_SERIAL, 12'd1, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_SERIAL, 12'd1, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_SERIAL, 12'd3, 32'd0, 64'd0);
        // LIFO reuse of freed slots.
        send_command(sia_pkg::CMD_FREE, 12'd1, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'd7, {$urandom, $urandom});
        send_command(sia_pkg::CMD_FREE, 12'd0, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_FREE, 12'd2, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'd9, {$urandom, $urandom});
        // A freed slot reads back serial zero.
        send_command(sia_pkg::CMD_SERIAL, 12'd0, 32'd0, 64'd0);
        // Double free pushes the same slot twice.
        send_command(sia_pkg::CMD_FREE, 12'd0, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'd11, {$urandom, $urandom});
        send_command(sia_pkg::CMD_ALLOC, 12'd0, 32'd12, {$urandom, $urandom});
        send_command(sia_pkg::CMD_FREE, 12'hFFF, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_SERIAL, 12'hFFF, 32'd0, 64'd0);
        send_command(CMD_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // Free everything, then once more with no live slot left.
        send_command(sia_pkg::CMD_FREE, 12'd0, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_FREE, 12'd1, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_FREE, 12'd2, 32'd0, 64'd0);
        send_command(sia_pkg::CMD_FREE, 12'd1, 32'd0, 64'd0);

        wait_drained();
        write_capacity(13'd0);
        run_random(100);
        wait_drained();
        write_capacity(13'd8);
        run_random(200);
        wait_drained();
        write_capacity(13'd1);
        run_random(60);
        wait_drained();
        write_capacity(13'd40);
        run_random(300);
        wait_drained();
        write_capacity(13'h1FFF);
        run_random(300);
        wait_drained();

        // Exhaust the remaining capacity, overshoot into full, then churn at the top end.
        write_capacity(CNT_W'(issued + 64));
        fill = 64 + stack_depth + 6;
        repeat (fill)
            send_command(sia_pkg::CMD_ALLOC, IDX_W'($urandom_range(0, sia_pkg::SLOTS_DEF - 1)),
                         $urandom, {$urandom, $urandom});
        run_random(80);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sia_pkg.sv
hw/rtl/sia_free_stack.sv
hw/rtl/sia_slot_store.sv
hw/rtl/sia_ctrl.sv
hw/rtl/slot_index_allocator_unit.sv
dv/slot_index_allocator_checker.sv
dv/slot_index_allocator_unit_tb.sv
